// File: rtl/mfe_pkg.sv
`timescale 1ns / 1ps
// Types, register codes and constants shared by the multipole field evaluator.
package mfe_pkg;

  // Highest multipole order that contributes to the field (1 to 4)
  localparam int MAX_ORDER = 4;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
  } point_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic               saturated;
  } field_t;

  typedef enum logic [2:0] {
    REG_NORMAL_DIPOLE     = 3'd0,
    REG_NORMAL_QUADRUPOLE = 3'd1,
    REG_NORMAL_SEXTUPOLE  = 3'd2,
    REG_NORMAL_OCTUPOLE   = 3'd3,
    REG_SKEW_DIPOLE       = 3'd4,
    REG_SKEW_QUADRUPOLE   = 3'd5,
    REG_SKEW_SEXTUPOLE    = 3'd6,
    REG_SKEW_OCTUPOLE     = 3'd7
  } cfg_reg_e;

  // ceil(2^20 / 3): exact floor division by three for any 19-bit value
  localparam logic [19:0] DIV3_MAGIC = 20'd349526;
  // 3 * 2^34: lifts the octupole quotient into the non-negative range
  localparam logic [35:0] DIV3_BIAS  = 36'd51539607552;
  // 2^34 = DIV3_BIAS / 3, taken back off after the division
  localparam logic [35:0] DIV3_UNBIAS = 36'd17179869184;

  function automatic logic [17:0] div3(input logic [18:0] a);
    logic [38:0] prod;
    prod = 39'(a) * 39'(DIV3_MAGIC);
    return prod[37:20];
  endfunction

endpackage

// File: rtl/multipole_field_evaluator_top.sv
`timescale 1ns / 1ps
// Multipole field evaluator: pipelined transverse field (Bx, By) of a magnet up to octupole.
//
// Each point (pos_x, pos_y, Q1.23 metres) yields one field item (Q8.24 tesla), and a new point
// can be accepted in every cycle: the nine register stages (powers of x+iy, per-order
// coefficient products, a two-digit divide by three for the octupole factorial, final sum and
// clip) each hold one item and close up bubbles on their own, so a stall on the field side
// only halts the input once every stage is full. Coefficients are written through the cfg port
// (always ready) and must only change while no point is in flight. A field component beyond the
// signed 32-bit range is clipped and flagged in saturated.
module multipole_field_evaluator_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_stall,
  input  mfe_pkg::point_t  point,
  output logic             field_valid,
  input  logic             field_stall,
  output mfe_pkg::field_t  field,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  import mfe_pkg::*;

  localparam int NSTAGE = 8;
  localparam logic USE_ORD2 = (MAX_ORDER >= 2);
  localparam logic USE_ORD3 = (MAX_ORDER >= 3);
  localparam logic USE_ORD4 = (MAX_ORDER >= 4);

  // coefficient registers, index 0 is the dipole
  logic signed [31:0] coef_normal [4];
  logic signed [31:0] coef_skew   [4];

  // stage valid bits and load enables; enable NSTAGE+1 belongs to the output register
  logic [NSTAGE:1]   valid;
  logic [NSTAGE+1:1] en;

  // stage 1: squares and the cross product
  logic signed [23:0] x_s1, y_s1;
  logic signed [47:0] xx_s1, yy_s1, xy_s1;
  // stage 2: z^2 in Q.28
  logic signed [23:0] x_s2, y_s2;
  logic signed [30:0] pr2_s2, pi2_s2;
  // stage 3: products for z^3 and the quadrupole and sextupole terms
  logic signed [54:0] zr_x_s3, zi_y_s3, zr_y_s3, zi_x_s3;
  logic signed [55:0] n2x_s3, s2y_s3, n2y_s3, s2x_s3;
  logic signed [62:0] n3r_s3, s3i_s3, n3i_s3, s3r_s3;
  // stage 4: z^3, rounded quadrupole and sextupole terms
  logic signed [31:0] pr3_s4, pi3_s4;
  logic signed [33:0] re2_s4, im2_s4;
  logic signed [34:0] re3_s4, im3_s4;
  // stage 5: octupole products
  logic signed [63:0] n4r_s5, s4i_s5, n4i_s5, s4r_s5;
  logic signed [33:0] re2_s5, im2_s5;
  logic signed [34:0] re3_s5, im3_s5;
  // stage 6: biased octupole numerators over 2^29
  logic [35:0]        ure_s6, uim_s6;
  logic signed [33:0] re2_s6, im2_s6;
  logic signed [34:0] re3_s6, im3_s6;
  // stage 7: high digit of the divide by three
  logic [17:0]        qhre_s7, qhim_s7;
  logic [1:0]         rhre_s7, rhim_s7;
  logic [16:0]        lore_s7, loim_s7;
  logic signed [33:0] re2_s7, im2_s7;
  logic signed [34:0] re3_s7, im3_s7;
  // stage 8: octupole terms
  logic signed [35:0] re4_s8, im4_s8;
  logic signed [33:0] re2_s8, im2_s8;
  logic signed [34:0] re3_s8, im3_s8;

  // combinational values between stages
  logic signed [48:0] d_re2, d_im2;
  logic signed [55:0] e_re3, e_im3;
  logic signed [56:0] t_re2, t_im2;
  logic signed [63:0] t_re3, t_im3;
  logic signed [64:0] t_re4, t_im4;
  logic [18:0]        hre, him, rem_re, rem_im;
  logic [17:0]        qhre, qhim, qlre, qlim;
  logic signed [39:0] sum_y, sum_x;
  field_t             field_next;

  // ---------------------------------------------------------------- configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        coef_normal[i] <= '0;
        coef_skew[i]   <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_NORMAL_DIPOLE:     coef_normal[0] <= cfg_data;
        REG_NORMAL_QUADRUPOLE: coef_normal[1] <= cfg_data;
        REG_NORMAL_SEXTUPOLE:  coef_normal[2] <= cfg_data;
        REG_NORMAL_OCTUPOLE:   coef_normal[3] <= cfg_data;
        REG_SKEW_DIPOLE:       coef_skew[0]   <= cfg_data;
        REG_SKEW_QUADRUPOLE:   coef_skew[1]   <= cfg_data;
        REG_SKEW_SEXTUPOLE:    coef_skew[2]   <= cfg_data;
        REG_SKEW_OCTUPOLE:     coef_skew[3]   <= cfg_data;
        default:               ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // a stage loads when it is empty or the stage after it loads too
  always_comb begin
    en[NSTAGE+1] = !field_valid || !field_stall;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign point_stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      field_valid <= 1'b0;
    end else begin
      if (en[1]) valid[1] <= point_valid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) valid[k] <= valid[k-1];
      end
      if (en[NSTAGE+1]) field_valid <= valid[NSTAGE];
    end
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    // z^2, rounded half up to Q.28
    d_re2 = 49'(xx_s1) - 49'(yy_s1) + 49'sd131072;
    d_im2 = 49'(xy_s1) + 49'sd65536;

    // z^3 and the quadrupole and sextupole terms
    e_re3 = 56'(zr_x_s3) - 56'(zi_y_s3) + 56'sd4194304;
    e_im3 = 56'(zr_y_s3) + 56'(zi_x_s3) + 56'sd4194304;
    t_re2 = 57'(n2x_s3) + 57'(s2y_s3) + 57'sd4194304;
    t_im2 = 57'(n2y_s3) - 57'(s2x_s3) + 57'sd4194304;
    t_re3 = 64'(n3r_s3) + 64'(s3i_s3) + 64'sd268435456;
    t_im3 = 64'(n3i_s3) - 64'(s3r_s3) + 64'sd268435456;

    // octupole: add half of 6 * 2^28, then floor by 2^29 here and by three later
    t_re4 = 65'(n4r_s5) + 65'(s4i_s5) + 65'sd805306368;
    t_im4 = 65'(n4i_s5) - 65'(s4r_s5) + 65'sd805306368;

    // long division by three, high digit
    hre    = ure_s6[35:17];
    him    = uim_s6[35:17];
    qhre   = div3(hre);
    qhim   = div3(him);
    rem_re = hre - ({1'b0, qhre} + {qhre, 1'b0});
    rem_im = him - ({1'b0, qhim} + {qhim, 1'b0});

    // low digit
    qlre = div3({rhre_s7, lore_s7});
    qlim = div3({rhim_s7, loim_s7});

    // sum the orders: the normal dipole adds, the skew dipole and the higher orders subtract
    sum_y = 40'(coef_normal[0])
          - (USE_ORD2 ? 40'(re2_s8) : 40'sd0)
          - (USE_ORD3 ? 40'(re3_s8) : 40'sd0)
          - (USE_ORD4 ? 40'(re4_s8) : 40'sd0);
    sum_x = 40'sd0 - 40'(coef_skew[0])
          - (USE_ORD2 ? 40'(im2_s8) : 40'sd0)
          - (USE_ORD3 ? 40'(im3_s8) : 40'sd0)
          - (USE_ORD4 ? 40'(im4_s8) : 40'sd0);

    field_next.saturated = 1'b0;
    if (sum_x > 40'sd2147483647) begin
      field_next.field_x   = 32'sh7fffffff;
      field_next.saturated = 1'b1;
    end else if (sum_x < -40'sd2147483648) begin
      field_next.field_x   = 32'sh80000000;
      field_next.saturated = 1'b1;
    end else begin
      field_next.field_x   = sum_x[31:0];
    end
    if (sum_y > 40'sd2147483647) begin
      field_next.field_y   = 32'sh7fffffff;
      field_next.saturated = 1'b1;
    end else if (sum_y < -40'sd2147483648) begin
      field_next.field_y   = 32'sh80000000;
      field_next.saturated = 1'b1;
    end else begin
      field_next.field_y   = sum_y[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_s1  <= point.pos_x;
      y_s1  <= point.pos_y;
      xx_s1 <= 48'(point.pos_x) * 48'(point.pos_x);
      yy_s1 <= 48'(point.pos_y) * 48'(point.pos_y);
      xy_s1 <= 48'(point.pos_x) * 48'(point.pos_y);
    end
    if (en[2]) begin
      x_s2   <= x_s1;
      y_s2   <= y_s1;
      pr2_s2 <= d_re2[48:18];
      pi2_s2 <= d_im2[47:17];
    end
    if (en[3]) begin
      zr_x_s3 <= 55'(pr2_s2) * 55'(x_s2);
      zi_y_s3 <= 55'(pi2_s2) * 55'(y_s2);
      zr_y_s3 <= 55'(pr2_s2) * 55'(y_s2);
      zi_x_s3 <= 55'(pi2_s2) * 55'(x_s2);
      n2x_s3  <= 56'(coef_normal[1]) * 56'(x_s2);
      s2y_s3  <= 56'(coef_skew[1]) * 56'(y_s2);
      n2y_s3  <= 56'(coef_normal[1]) * 56'(y_s2);
      s2x_s3  <= 56'(coef_skew[1]) * 56'(x_s2);
      n3r_s3  <= 63'(coef_normal[2]) * 63'(pr2_s2);
      s3i_s3  <= 63'(coef_skew[2]) * 63'(pi2_s2);
      n3i_s3  <= 63'(coef_normal[2]) * 63'(pi2_s2);
      s3r_s3  <= 63'(coef_skew[2]) * 63'(pr2_s2);
    end
    if (en[4]) begin
      pr3_s4 <= e_re3[54:23];
      pi3_s4 <= e_im3[54:23];
      re2_s4 <= t_re2[56:23];
      im2_s4 <= t_im2[56:23];
      re3_s4 <= t_re3[63:29];
      im3_s4 <= t_im3[63:29];
    end
    if (en[5]) begin
      n4r_s5 <= 64'(coef_normal[3]) * 64'(pr3_s4);
      s4i_s5 <= 64'(coef_skew[3]) * 64'(pi3_s4);
      n4i_s5 <= 64'(coef_normal[3]) * 64'(pi3_s4);
      s4r_s5 <= 64'(coef_skew[3]) * 64'(pr3_s4);
      re2_s5 <= re2_s4;
      im2_s5 <= im2_s4;
      re3_s5 <= re3_s4;
      im3_s5 <= im3_s4;
    end
    if (en[6]) begin
      ure_s6 <= t_re4[64:29] + DIV3_BIAS;
      uim_s6 <= t_im4[64:29] + DIV3_BIAS;
      re2_s6 <= re2_s5;
      im2_s6 <= im2_s5;
      re3_s6 <= re3_s5;
      im3_s6 <= im3_s5;
    end
    if (en[7]) begin
      qhre_s7 <= qhre;
      qhim_s7 <= qhim;
      rhre_s7 <= rem_re[1:0];
      rhim_s7 <= rem_im[1:0];
      lore_s7 <= ure_s6[16:0];
      loim_s7 <= uim_s6[16:0];
      re2_s7  <= re2_s6;
      im2_s7  <= im2_s6;
      re3_s7  <= re3_s6;
      im3_s7  <= im3_s6;
    end
    if (en[8]) begin
      // drop the bias again: quotient of the bias is 2^34
      re4_s8 <= {1'b0, qhre_s7, 17'd0} + 36'(qlre) - DIV3_UNBIAS;
      im4_s8 <= {1'b0, qhim_s7, 17'd0} + 36'(qlim) - DIV3_UNBIAS;
      re2_s8 <= re2_s7;
      im2_s8 <= im2_s7;
      re3_s8 <= re3_s7;
      im3_s8 <= im3_s7;
    end
    if (en[NSTAGE+1]) begin
      field <= field_next;
    end
  end

endmodule
